// File: design/ros_pkg.sv
// ----------------------------------------------------------------------------
// ros_pkg
// shared types and constants of the oriented box slab test core
// ----------------------------------------------------------------------------
package ros_pkg;

  // numerator magnitude, divisor magnitude, quotient bits of the slab divide
  localparam int NW      = 50;
  localparam int DW      = 32;
  localparam int QB      = 31;
  localparam int CW      = 64;
  localparam int DIV_LAT = QB + 1;

  localparam logic signed [31:0] FULL     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEG_FULL = -32'sh7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_CENTER = 3'd0,
    REG_AXIS_A = 3'd1,
    REG_AXIS_B = 3'd2,
    REG_AXIS_C = 3'd3,
    REG_HALF   = 3'd4,
    REG_EPS    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [47:0] center;
    logic [47:0] axis_a;
    logic [47:0] axis_b;
    logic [47:0] axis_c;
    logic [47:0] half;
    logic [15:0] eps;
  } cfg_t;

  typedef struct packed {
    logic          par;
    logic          pmiss;
    logic [NW-1:0] n1_mag;
    logic          n1_neg;
    logic [NW-1:0] n2_mag;
    logic          n2_neg;
    logic [DW-1:0] d_mag;
    logic          d_neg;
  } axis_job_t;

  typedef struct packed {
    logic                func;
    logic [30:0]         len;
    axis_job_t [2:0]     ax;
  } slab_item_t;

  function automatic logic signed [15:0] comp16(input logic [47:0] w, input int k);
    comp16 = $signed(w[16*k +: 16]);
  endfunction

endpackage

// File: design/ros_front.sv
// ----------------------------------------------------------------------------
// ros_front
// projects center offset and direction on the box axes, classifies each axis
// ----------------------------------------------------------------------------
module ros_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ros_pkg::cfg_t      cfg_i,
  input  logic               en_i,
  input  logic               accept_i,
  input  logic               func_i,
  input  logic [47:0]        ray_origin_i,
  input  logic [47:0]        ray_direction_i,
  input  logic [30:0]        segment_length_i,
  output logic               push_o,
  output ros_pkg::slab_item_t item_o
);
  import ros_pkg::*;

  logic [47:0] axes [3];

  // stage a: offsets
  logic               a_valid_q;
  logic signed [16:0] a_off_q [3];
  logic signed [15:0] a_dir_q [3];
  logic               a_func_q;
  logic [30:0]        a_len_q;

  // stage b: products
  logic               b_valid_q;
  logic signed [32:0] b_pe_q [3][3];
  logic signed [32:0] b_pf_q [3][3];
  logic               b_func_q;
  logic [30:0]        b_len_q;
  logic signed [32:0] pe_d [3][3];
  logic signed [32:0] pf_d [3][3];

  // stage c: dot sums
  logic               c_valid_q;
  logic signed [34:0] c_e_q [3];
  logic signed [34:0] c_f_q [3];
  logic signed [23:0] c_h_q [3];
  logic               c_func_q;
  logic [30:0]        c_len_q;

  assign axes[0] = cfg_i.axis_a;
  assign axes[1] = cfg_i.axis_b;
  assign axes[2] = cfg_i.axis_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= accept_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && accept_i) begin
      for (int k = 0; k < 3; k++) begin
        a_off_q[k] <= 17'(comp16(cfg_i.center, k)) - 17'(comp16(ray_origin_i, k));
        a_dir_q[k] <= comp16(ray_direction_i, k);
      end
      a_func_q <= func_i;
      a_len_q  <= segment_length_i;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        pe_d[j][k] = 33'(comp16(axes[j], k)) * 33'(a_off_q[k]);
        pf_d[j][k] = 33'(comp16(axes[j], k)) * 33'(a_dir_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_pe_q   <= pe_d;
      b_pf_q   <= pf_d;
      b_func_q <= a_func_q;
      b_len_q  <= a_len_q;
      for (int j = 0; j < 3; j++) begin
        c_e_q[j] <= 35'(b_pe_q[j][0]) + 35'(b_pe_q[j][1]) + 35'(b_pe_q[j][2]);
        c_f_q[j] <= 35'(b_pf_q[j][0]) + 35'(b_pf_q[j][1]) + 35'(b_pf_q[j][2]);
        c_h_q[j] <= {comp16(cfg_i.half, j), 8'h00};
      end
      c_func_q <= b_func_q;
      c_len_q  <= b_len_q;
    end
  end

  // classify and form slab numerators, the queue registers them
  always_comb begin
    logic signed [35:0] e36, h36, n1, n2;
    logic [34:0]        fabs;
    logic [35:0]        n1abs, n2abs;
    item_o.func = c_func_q;
    item_o.len  = c_len_q;
    for (int j = 0; j < 3; j++) begin
      e36   = 36'(c_e_q[j]);
      h36   = 36'(c_h_q[j]);
      n1    = e36 + h36;
      n2    = e36 - h36;
      fabs  = c_f_q[j][34] ? 35'(-c_f_q[j]) : 35'(c_f_q[j]);
      n1abs = n1[35] ? 36'(-n1) : 36'(n1);
      n2abs = n2[35] ? 36'(-n2) : 36'(n2);
      item_o.ax[j].par    = !(fabs > {19'd0, cfg_i.eps});
      item_o.ax[j].pmiss  = !(fabs > {19'd0, cfg_i.eps}) && ((e36 < -h36) || (e36 > h36));
      item_o.ax[j].n1_mag = {n1abs[NW-17:0], 16'h0000};
      item_o.ax[j].n1_neg = n1[35];
      item_o.ax[j].n2_mag = {n2abs[NW-17:0], 16'h0000};
      item_o.ax[j].n2_neg = n2[35];
      item_o.ax[j].d_mag  = fabs[DW-1:0];
      item_o.ax[j].d_neg  = c_f_q[j][34];
    end
  end

  assign push_o = c_valid_q && en_i;

endmodule

// File: design/ros_fifo.sv
// ----------------------------------------------------------------------------
// ros_fifo
// two-entry queue between front and back, drained whenever not empty
// ----------------------------------------------------------------------------
module ros_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ros_pkg::slab_item_t item_i,
  output logic                valid_o,
  output ros_pkg::slab_item_t item_o,
  output logic                full_o
);
  import ros_pkg::*;

  slab_item_t mem [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = (cnt_q != 2'd0);
  assign valid_o = pop;
  assign full_o  = (cnt_q == 2'd2);
  assign item_o  = mem[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wptr_q] <= item_i;
  end

endmodule

// File: design/ros_div.sv
// ----------------------------------------------------------------------------
// ros_div
// pipelined restoring divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
module ros_div (
  input  logic                        clk_i,
  input  logic [ros_pkg::NW-1:0]      n_i,
  input  logic                        neg_i,
  input  logic [ros_pkg::DW-1:0]      d_i,
  output logic signed [31:0]          q_o
);
  import ros_pkg::*;

  logic [NW-1:0] r_q   [DIV_LAT];
  logic [DW-1:0] d_q   [DIV_LAT];
  logic          neg_q [DIV_LAT];
  logic          sat_q [DIV_LAT];
  logic [QB-1:0] quo_q [DIV_LAT];
  logic [QB-1:0] mag;

  // quotient of 2^31 or more saturates
  always_ff @(posedge clk_i) begin
    r_q[0]   <= n_i;
    d_q[0]   <= d_i;
    neg_q[0] <= neg_i;
    sat_q[0] <= {{(CW-NW){1'b0}}, n_i} >= ({{(CW-DW){1'b0}}, d_i} << QB);
    quo_q[0] <= '0;
  end

  for (genvar i = 1; i < DIV_LAT; i++) begin : g_stage
    localparam int B = QB - i;
    logic [CW-1:0] sh;
    logic [CW-1:0] rx;
    logic          ge;
    assign sh = {{(CW-DW){1'b0}}, d_q[i-1]} << B;
    assign rx = {{(CW-NW){1'b0}}, r_q[i-1]};
    assign ge = rx >= sh;
    always_ff @(posedge clk_i) begin
      r_q[i]   <= ge ? NW'(rx - sh) : r_q[i-1];
      d_q[i]   <= d_q[i-1];
      neg_q[i] <= neg_q[i-1];
      sat_q[i] <= sat_q[i-1];
      quo_q[i] <= quo_q[i-1] | (QB'(ge) << B);
    end
  end

  assign mag = sat_q[DIV_LAT-1] ? {QB{1'b1}} : quo_q[DIV_LAT-1];
  assign q_o = neg_q[DIV_LAT-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// File: design/ros_back.sv
// ----------------------------------------------------------------------------
// ros_back
// slab distances, interval clipping and final hit decision
// ----------------------------------------------------------------------------
module ros_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ros_pkg::slab_item_t item_i,
  output logic                done_o,
  output logic                hit_o,
  output logic signed [31:0]  distance_o
);
  import ros_pkg::*;

  typedef struct packed {
    logic        func;
    logic [30:0] len;
    logic [2:0]  par;
    logic [2:0]  pmiss;
  } side_t;

  side_t              side_d;
  side_t              side_q [DIV_LAT];
  logic               sv_q [DIV_LAT];
  logic signed [31:0] t1 [3];
  logic signed [31:0] t2 [3];

  logic               x_valid_q;
  logic signed [31:0] x_lo_q [3];
  logic signed [31:0] x_hi_q [3];
  logic               x_func_q;
  logic [30:0]        x_len_q;
  logic               x_miss_q;

  logic               y_valid_q;
  logic signed [31:0] y_tmin_q, y_tmax_q;
  logic               y_func_q;
  logic [30:0]        y_len_q;
  logic               y_miss_q;
  logic signed [31:0] tmin_d, tmax_d;

  logic               done_q, hit_q;
  logic signed [31:0] dist_q;
  logic               hit_d;
  logic signed [31:0] dist_d;

  for (genvar j = 0; j < 3; j++) begin : g_axis
    ros_div u_div1 (
      .clk_i (clk_i),
      .n_i   (item_i.ax[j].n1_mag),
      .neg_i (item_i.ax[j].n1_neg ^ item_i.ax[j].d_neg),
      .d_i   (item_i.ax[j].d_mag),
      .q_o   (t1[j])
    );
    ros_div u_div2 (
      .clk_i (clk_i),
      .n_i   (item_i.ax[j].n2_mag),
      .neg_i (item_i.ax[j].n2_neg ^ item_i.ax[j].d_neg),
      .d_i   (item_i.ax[j].d_mag),
      .q_o   (t2[j])
    );
    assign side_d.par[j]   = item_i.ax[j].par;
    assign side_d.pmiss[j] = item_i.ax[j].pmiss;
  end
  assign side_d.func = item_i.func;
  assign side_d.len  = item_i.len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) sv_q[i] <= 1'b0;
      x_valid_q <= 1'b0;
      y_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      sv_q[0] <= valid_i;
      for (int i = 1; i < DIV_LAT; i++) sv_q[i] <= sv_q[i-1];
      x_valid_q <= sv_q[DIV_LAT-1];
      y_valid_q <= x_valid_q;
      done_q    <= y_valid_q;
    end
  end

  // ordered slab ends, parallel axes leave the interval open
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < DIV_LAT; i++) side_q[i] <= side_q[i-1];
    for (int j = 0; j < 3; j++) begin
      if (side_q[DIV_LAT-1].par[j]) begin
        x_lo_q[j] <= NEG_FULL;
        x_hi_q[j] <= FULL;
      end else if (t1[j] > t2[j]) begin
        x_lo_q[j] <= t2[j];
        x_hi_q[j] <= t1[j];
      end else begin
        x_lo_q[j] <= t1[j];
        x_hi_q[j] <= t2[j];
      end
    end
    x_func_q <= side_q[DIV_LAT-1].func;
    x_len_q  <= side_q[DIV_LAT-1].len;
    x_miss_q <= |side_q[DIV_LAT-1].pmiss;
  end

  always_comb begin
    tmin_d = NEG_FULL;
    tmax_d = FULL;
    for (int j = 0; j < 3; j++) begin
      if (x_lo_q[j] > tmin_d) tmin_d = x_lo_q[j];
      if (x_hi_q[j] < tmax_d) tmax_d = x_hi_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    y_tmin_q <= tmin_d;
    y_tmax_q <= tmax_d;
    y_func_q <= x_func_q;
    y_len_q  <= x_len_q;
    y_miss_q <= x_miss_q;
  end

  // the interval only shrinks, so one check at the end covers every axis
  always_comb begin
    logic signed [31:0] lens;
    lens   = $signed({1'b0, y_len_q});
    hit_d  = !y_miss_q && !(y_tmin_q > y_tmax_q) && !(y_tmax_q < 0);
    dist_d = '0;
    if (hit_d) begin
      if (!y_func_q) begin
        dist_d = (y_tmin_q > 0) ? y_tmin_q : y_tmax_q;
      end else if ((y_tmin_q > 0) && (y_tmin_q <= lens)) begin
        dist_d = y_tmin_q;
      end else if (y_tmax_q > lens) begin
        hit_d = 1'b0;
      end else begin
        dist_d = y_tmax_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    dist_q <= dist_d;
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign distance_o = dist_q;

endmodule

// File: design/ray_obb_slab_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_obb_slab_intersect_core
// ray or segment against one oriented box, slab test on the three box axes
// ----------------------------------------------------------------------------
//
//  channel   | signals                                        | flow
//  ----------+------------------------------------------------+-------------
//  command   | start, busy, func_i, ray_origin_i,             | in
//            | ray_direction_i, segment_length_i              |
//  result    | done_o, hit_o, distance_o                      | out, no stall
//  config    | psel, penable, pwrite, paddr, pwdata, prdata,  | apb, 64 bit
//            | pready                                         |
//
//  one transaction is accepted per cycle while busy is low; each result
//  passes 3 projection stages, 1 queue stage, 32 divider stages and 3 clip
//  and decision stages; the latency is set by the bit-per-stage slab dividers.
//  busy only rises if the front queue fills, which the always-draining back
//  end clears in the next cycle. reset is asynchronous, active low, and
//  clears the box to zero and parallel_epsilon to one. results cannot be held.
// ----------------------------------------------------------------------------
module ray_obb_slab_intersect_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [47:0]        ray_origin_i,
  input  logic [47:0]        ray_direction_i,
  input  logic [30:0]        segment_length_i,
  // result
  output logic               done_o,
  output logic               hit_o,
  output logic signed [31:0] distance_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import ros_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_we;
  reg_idx_e   cfg_idx;

  logic       accept;
  logic       fifo_full;
  logic       front_push;
  slab_item_t front_item;
  logic       back_valid;
  slab_item_t back_item;

  // register file, index taken from the 8-byte aligned address
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center <= '0;
      cfg_q.axis_a <= '0;
      cfg_q.axis_b <= '0;
      cfg_q.axis_c <= '0;
      cfg_q.half   <= '0;
      cfg_q.eps    <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CENTER: cfg_q.center <= pwdata[47:0];
        REG_AXIS_A: cfg_q.axis_a <= pwdata[47:0];
        REG_AXIS_B: cfg_q.axis_b <= pwdata[47:0];
        REG_AXIS_C: cfg_q.axis_c <= pwdata[47:0];
        REG_HALF:   cfg_q.half   <= pwdata[47:0];
        REG_EPS:    cfg_q.eps    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER: prdata = {16'd0, cfg_q.center};
      REG_AXIS_A: prdata = {16'd0, cfg_q.axis_a};
      REG_AXIS_B: prdata = {16'd0, cfg_q.axis_b};
      REG_AXIS_C: prdata = {16'd0, cfg_q.axis_c};
      REG_HALF:   prdata = {16'd0, cfg_q.half};
      REG_EPS:    prdata = {48'd0, cfg_q.eps};
      default:    prdata = '0;
    endcase
  end

  // front stalls as a whole only while the queue is full
  assign busy   = fifo_full;
  assign accept = start && !busy;

  ros_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .en_i             (!fifo_full),
    .accept_i         (accept),
    .func_i           (func_i),
    .ray_origin_i     (ray_origin_i),
    .ray_direction_i  (ray_direction_i),
    .segment_length_i (segment_length_i),
    .push_o           (front_push),
    .item_o           (front_item)
  );

  ros_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .item_i  (front_item),
    .valid_o (back_valid),
    .item_o  (back_item),
    .full_o  (fifo_full)
  );

  // back end never stalls: one divider pipeline lane per slab plane
  ros_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (back_valid),
    .item_i     (back_item),
    .done_o     (done_o),
    .hit_o      (hit_o),
    .distance_o (distance_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_push |-> !fifo_full) else $error("queue push while full");

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("busy held for more than one cycle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (distance_o == 32'sd0)) else $error("miss with distance");

  a_hit_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> !distance_o[31]) else $error("hit with negative distance");
`endif

endmodule

// File: verif/ray_obb_slab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_obb_slab_checker
// watches the command, result and configuration channels of the slab core,
// predicts each hit and distance, and compares them in order
// ----------------------------------------------------------------------------
module ray_obb_slab_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               func_i,
  input  logic [47:0]        ray_origin_i,
  input  logic [47:0]        ray_direction_i,
  input  logic [30:0]        segment_length_i,
  input  logic               done_i,
  input  logic               hit_i,
  input  logic signed [31:0] distance_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [5:0]         paddr_i,
  input  logic [63:0]        pwdata_i,
  input  logic               pready_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 hit_count_o
);
  import ros_pkg::*;

  typedef struct {
    bit               hit;
    logic signed [31:0] dval;
  } slab_answer_t;

  localparam longint SAT = 64'sd2147483647;

  logic [47:0] box_ctr, ax_a, ax_b, ax_c, half_len;
  logic [15:0] eps_q16;
  slab_answer_t answer_q[$];

  function automatic longint lane(input logic [47:0] w, input int k);
    logic signed [15:0] c;
    c = w[16*k +: 16];
    return longint'(c);
  endfunction

  function automatic longint sat_div(input longint num, input longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > SAT) q = SAT;
    if (q < -SAT) q = -SAT;
    return q;
  endfunction

  function automatic slab_answer_t predict_slab(input logic fn, input logic [47:0] org,
                                                input logic [47:0] dir, input logic [30:0] len);
    slab_answer_t r;
    logic [47:0] axes [3];
    longint off [3];
    longint dv [3];
    longint tmin, tmax, e, f, h, af, t1, t2, tmp, slen;
    bit ok;
    axes[0] = ax_a; axes[1] = ax_b; axes[2] = ax_c;
    tmin = -SAT; tmax = SAT; ok = 1; slen = longint'(len);
    for (int k = 0; k < 3; k++) begin
      off[k] = lane(box_ctr, k) - lane(org, k);
      dv[k]  = lane(dir, k);
    end
    for (int k = 0; k < 3; k++) begin
      if (ok) begin
        e = 0; f = 0;
        for (int j = 0; j < 3; j++) begin
          e += lane(axes[k], j) * off[j];
          f += lane(axes[k], j) * dv[j];
        end
        h  = lane(half_len, k) * 256;
        af = f < 0 ? -f : f;
        if (af > longint'(eps_q16)) begin
          t1 = sat_div(e + h, f);
          t2 = sat_div(e - h, f);
          if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
          end
          if (t1 > tmin) tmin = t1;
          if (t2 < tmax) tmax = t2;
          if (tmin > tmax || tmax < 0) ok = 0;
        end else if (e < -h || e > h) begin
          ok = 0;
        end
      end
    end
    r.dval = 0;
    if (ok) begin
      if (!fn) r.dval = tmin > 0 ? tmin[31:0] : tmax[31:0];
      else if (tmin > 0 && tmin <= slen) r.dval = tmin[31:0];
      else if (tmax > slen) ok = 0;
      else r.dval = tmax[31:0];
    end
    if (!ok) r.dval = 0;
    r.hit = ok;
    return r;
  endfunction

  assign pending_o = answer_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    slab_answer_t want;
    if (!rst_ni) begin
      box_ctr <= '0; ax_a <= '0; ax_b <= '0; ax_c <= '0; half_len <= '0;
      eps_q16 <= 16'd1;
      fail_count_o <= 0;
      hit_count_o <= 0;
      answer_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[5:3]))
          REG_CENTER: box_ctr  <= pwdata_i[47:0];
          REG_AXIS_A: ax_a     <= pwdata_i[47:0];
          REG_AXIS_B: ax_b     <= pwdata_i[47:0];
          REG_AXIS_C: ax_c     <= pwdata_i[47:0];
          REG_HALF:   half_len <= pwdata_i[47:0];
          REG_EPS:    eps_q16  <= pwdata_i[15:0];
          default: ;
        endcase
      end
      // results come out before the new command is pushed
      if (done_i) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0b distance=%0d", $time, hit_i, distance_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answer_q.pop_front();
          if (want.hit !== hit_i || want.dval !== distance_i) begin
            $display("%0t: mismatch expected hit=%0b distance=%0d, actual hit=%0b distance=%0d",
                     $time, want.hit, want.dval, hit_i, distance_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (hit_i) hit_count_o <= hit_count_o + 1;
        end
      end
      if (start_i && !busy_i)
        answer_q.push_back(predict_slab(func_i, ray_origin_i, ray_direction_i,
                                        segment_length_i));
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus for the oriented box slab core: box settings over apb, directed
// and random rays and segments in bursts, verdict from the checker
// ----------------------------------------------------------------------------
module testbench;
  import ros_pkg::*;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic               func = 0;
  logic [47:0]        org = '0;
  logic [47:0]        dir = '0;
  logic [30:0]        seg_len = '0;
  logic               done, hit;
  logic signed [31:0] distance;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [5:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;
  int                 fails, pending, hits;
  int                 sent = 0;
  int                 burst_left = 0;

  // generous margin past the depth of the pipeline
  localparam int DRAIN = 60;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  ray_obb_slab_intersect_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .start(start), .busy(busy),
    .func_i(func), .ray_origin_i(org), .ray_direction_i(dir), .segment_length_i(seg_len),
    .done_o(done), .hit_o(hit), .distance_o(distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ray_obb_slab_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .start_i(start), .busy_i(busy), .func_i(func), .ray_origin_i(org),
    .ray_direction_i(dir), .segment_length_i(seg_len),
    .done_i(done), .hit_i(hit), .distance_i(distance),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fails), .pending_o(pending), .hit_count_o(hits)
  );

  // wait for every outstanding transaction to drain, then pipeline slack
  task automatic drain_all();
    start <= 0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // setup then access phase; registers are 64 bit so index i sits at 8*i
  task automatic reg_write(input reg_idx_e idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic load_box(input logic [47:0] c, input logic [47:0] a, input logic [47:0] b,
                          input logic [47:0] cc, input logic [47:0] h, input logic [15:0] e);
    drain_all();
    reg_write(REG_CENTER, {16'h0, c});
    reg_write(REG_AXIS_A, {16'h0, a});
    reg_write(REG_AXIS_B, {16'h0, b});
    reg_write(REG_AXIS_C, {16'h0, cc});
    reg_write(REG_HALF, {16'h0, h});
    reg_write(REG_EPS, {48'h0, e});
  endtask

  // one command transaction; start stays high across a burst
  task automatic send_ray(input logic f, input logic [47:0] o, input logic [47:0] d,
                          input logic [30:0] l);
    logic was_busy;
    if (burst_left == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    start <= 1; func <= f; org <= o; dir <= d; seg_len <= l;
    // busy only moves at the rising edge, so its value at the falling edge holds
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    burst_left--;
    sent++;
  endtask

  function automatic logic [47:0] pack3(input int x, input int y, input int z);
    logic [15:0] a, b, c;
    a = x[15:0]; b = y[15:0]; c = z[15:0];
    return {c, b, a};
  endfunction

  // small signed Q7.8 component around zero
  function automatic int near(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [47:0] rand_vec(input int span);
    return pack3(near(span), near(span), near(span));
  endfunction

  function automatic logic [30:0] rand_len();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  // aim at the box most of the time so the clip stages get exercised
  task automatic random_phase(input int n, input logic [47:0] ctr);
    logic [47:0] o, d;
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        o = pack3($signed(ctr[15:0]) + near(2048), $signed(ctr[31:16]) + near(2048),
                  $signed(ctr[47:32]) + near(2048));
        d = pack3(($signed(ctr[15:0]) - $signed(o[15:0])) / 4 + near(64),
                  ($signed(ctr[31:16]) - $signed(o[31:16])) / 4 + near(64),
                  ($signed(ctr[47:32]) - $signed(o[47:32])) / 4 + near(64));
      end else if (roll < 9) begin
        o = rand_vec(1024);
        d = rand_vec(256);
      end else begin
        o = 48'({$urandom(), $urandom()});
        d = 48'({$urandom(), $urandom()});
      end
      send_ray(1'($urandom_range(0, 1)), o, d, rand_len());
      if (i == n / 2 && $urandom_range(0, 1)) drain_all();
    end
  endtask

  localparam logic [47:0] UX = 48'h0000_0000_0100;
  localparam logic [47:0] UY = 48'h0000_0100_0000;
  localparam logic [47:0] UZ = 48'h0100_0000_0000;

  initial begin
    logic [47:0] ctr;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset box: all zero, every axis parallel; the zero-length segment misses
    send_ray(0, '0, '0, '0);
    send_ray(1, '1, '1, 31'h7FFF_FFFF);
    send_ray(1, pack3(100, -100, 5), UX, 31'd0);

    // axis aligned unit box of half size 2 at the origin
    load_box('0, UX, UY, UZ, pack3(512, 512, 512), 16'd1);
    send_ray(0, pack3(-2560, 0, 0), UX, '0);           // enters from outside
    send_ray(0, pack3(0, 0, 0), UX, '0);               // starts inside
    send_ray(0, pack3(2560, 0, 0), UX, '0);            // box behind origin
    send_ray(0, pack3(-2560, 2560, 0), UX, '0);        // parallel axis outside
    send_ray(1, pack3(-2560, 0, 0), UX, 31'h0002_0000); // segment too short
    send_ray(1, pack3(-2560, 0, 0), UX, 31'h0010_0000); // segment reaches entry
    send_ray(1, pack3(0, 0, 0), UX, 31'h0001_0000);    // inside, exit past end
    send_ray(1, pack3(0, 0, 0), UX, 31'h0004_0000);    // inside, exit reached
    send_ray(0, pack3(-2560, -2560, -2560), pack3(256, 256, 256), '0);
    send_ray(0, pack3(-32768, 0, 0), pack3(1, 0, 0), '0);   // saturating divide
    send_ray(0, pack3(32767, 32767, 32767), pack3(-32768, -32768, -32768), '0);
    send_ray(0, '0, '0, '0);                           // all axes parallel, inside
    send_ray(1, pack3(1000, 1000, 1000), '0, '0);      // all parallel, outside

    // negative half lengths, zero epsilon, full-scale values
    load_box(48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, '0,
             48'h8000_7FFF_8000, 16'd0);
    send_ray(0, '1, pack3(1, 0, 0), '0);
    send_ray(1, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 31'h7FFF_FFFF);
    send_ray(0, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, '0);
    send_ray(1, '0, 48'h5555_AAAA_5555, 31'h2AAA_AAAA);

    // random phases over a spread of boxes
    load_box(pack3(256, -512, 768), UX, UY, UZ, pack3(384, 256, 640), 16'd1);
    random_phase(140, pack3(256, -512, 768));
    // rotated 45 degrees about z, large epsilon
    load_box('0, pack3(181, 181, 0), pack3(-181, 181, 0), UZ, pack3(512, 256, 768),
             16'hFFFF);
    random_phase(80, '0);
    load_box('0, pack3(181, 181, 0), pack3(-181, 181, 0), UZ, pack3(512, 256, 768),
             16'd300);
    random_phase(140, '0);

    // pause with nothing in flight, then carry on
    drain_all();
    ctr = rand_vec(1500);
    load_box(ctr, UY, UZ, UX, pack3(1024, 200, 700), 16'd16);
    random_phase(160, ctr);
    for (int p = 0; p < 3; p++) begin
      ctr = rand_vec(3000);
      load_box(ctr, rand_vec(256), rand_vec(256), rand_vec(256), rand_vec(1024),
               16'($urandom_range(0, 65535)));
      random_phase(60, ctr);
    end

    drain_all();
    $display("covered %0d rays and segments over 9 box settings, %0d hits", sent, hits);
    $display("epsilon from zero to full scale, negative halves, saturated divides");
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
